/* rtl/wqt_pkg.sv */
// wqt_pkg: shared types and constants of the wait queue table.
// Holds field widths, operation and status codes, and the command and
// status structs between controller and datapath. No dependencies.
package wqt_pkg;

	// Default sizes handed to the top level parameters
	localparam int DEPTH_DEF    = 16;
	localparam int TID_BITS_DEF = 16;

	// Fixed port field widths
	localparam int OP_W     = 2;
	localparam int ADDR_W   = 48;
	localparam int TID_W    = 16;
	localparam int CNT_W    = 5;
	localparam int STATUS_W = 3;

	typedef enum logic [OP_W-1:0] {
		OP_PUSH = 2'd0,
		OP_DROP = 2'd1,
		OP_WAKE = 2'd2,
		OP_RSVD = 2'd3
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_WOKEN   = 3'd0,
		ST_NONE    = 3'd1,
		ST_PUSHED  = 3'd2,
		ST_FULL    = 3'd3,
		ST_DROPPED = 3'd4
	} status_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic load;
		logic inc_i;
		logic rd_cur;
		logic rd_top;
		logic push_wr;
		logic mov_wr;
		logic dec_cnt;
		logic take_match;
		logic emit_push;
		logic emit_fin;
	} cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic full;
		logic scan_done;
		logic match;
		logic last_slot;
		logic out_free;
		logic pend_valid;
	} sts_t;

endpackage

/* rtl/wqt_ram.sv */
// wqt_ram: generic single write port RAM with one registered read port.
// No dependencies.
module wqt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write, and register the read data
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* rtl/wqt_ctrl.sv */
// wqt_ctrl: sequencer of the wait queue table.
// Walks push, drop and wake through read, compare and move steps.
// Depends on wqt_pkg.
module wqt_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  logic [wqt_pkg::OP_W-1:0]  in_op,
	output logic                      in_stall,
	input  wqt_pkg::sts_t             sts,
	output wqt_pkg::cmd_t             cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_PUSH,
		S_RD,
		S_CHK,
		S_MOV,
		S_FIN
	} state_t;

	state_t state_q;
	state_t state_nx;

	// Decode commands and next state
	always_comb begin
		cmd      = '0;
		state_nx = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					case (wqt_pkg::op_t'(in_op))
						wqt_pkg::OP_PUSH: state_nx = S_PUSH;
						wqt_pkg::OP_DROP,
						wqt_pkg::OP_WAKE: state_nx = S_RD;
						default:          state_nx = S_IDLE;
					endcase
				end
			end
			S_PUSH: begin
				if (sts.out_free) begin
					cmd.emit_push = 1'b1;
					cmd.push_wr   = !sts.full;
					state_nx      = S_IDLE;
				end
			end
			S_RD: begin
				if (sts.scan_done) begin
					state_nx = S_FIN;
				end else begin
					cmd.rd_cur = 1'b1;
					state_nx   = S_CHK;
				end
			end
			S_CHK: begin
				if (!sts.match) begin
					cmd.inc_i = 1'b1;
					state_nx  = S_RD;
				end else if (!sts.pend_valid || sts.out_free) begin
					// Take the match; swap the top entry in unless it is the match
					cmd.take_match = 1'b1;
					if (sts.last_slot) begin
						cmd.dec_cnt = 1'b1;
						state_nx    = S_RD;
					end else begin
						cmd.rd_top = 1'b1;
						state_nx   = S_MOV;
					end
				end
			end
			S_MOV: begin
				cmd.mov_wr  = 1'b1;
				cmd.dec_cnt = 1'b1;
				state_nx    = S_RD;
			end
			S_FIN: begin
				if (sts.out_free) begin
					cmd.emit_fin = 1'b1;
					state_nx     = S_IDLE;
				end
			end
			default: state_nx = S_IDLE;
		endcase
	end

	// Hold state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	assign in_stall = (state_q != S_IDLE);

endmodule

/* rtl/wqt_dpath.sv */
// wqt_dpath: entry store, scan index, counters and result register.
// Depends on wqt_pkg and wqt_ram.
module wqt_dpath #(
	parameter int DEPTH    = wqt_pkg::DEPTH_DEF,
	parameter int TID_BITS = wqt_pkg::TID_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  wqt_pkg::cmd_t                 cmd,
	output wqt_pkg::sts_t                 sts,
	input  logic [wqt_pkg::OP_W-1:0]      operation,
	input  logic [wqt_pkg::ADDR_W-1:0]    wait_address,
	input  logic [wqt_pkg::TID_W-1:0]     thread_id,
	input  logic [wqt_pkg::CNT_W-1:0]     wake_count,
	input  logic                          wake_all,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [wqt_pkg::STATUS_W-1:0]  status,
	output logic [wqt_pkg::TID_W-1:0]     woken_thread,
	output logic [wqt_pkg::CNT_W-1:0]     removed_count,
	output logic                          last
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int LW = (CW > wqt_pkg::CNT_W) ? CW : wqt_pkg::CNT_W;
	localparam int WW = wqt_pkg::ADDR_W + TID_BITS;

	wqt_pkg::op_t                op_q;
	logic [wqt_pkg::ADDR_W-1:0]  addr_q;
	logic [TID_BITS-1:0]         tid_q;
	logic [LW-1:0]               left_q;
	logic [CW-1:0]               i_q;
	logic [CW-1:0]               cnt_q;
	logic [CW-1:0]               removed_q;
	logic [TID_BITS-1:0]         pend_tid_q;
	logic                        pend_valid_q;

	logic                        out_valid_q;
	wqt_pkg::status_t            status_q;
	logic [wqt_pkg::TID_W-1:0]   woken_q;
	logic [wqt_pkg::CNT_W-1:0]   removed_out_q;
	logic                        last_q;

	logic                        ram_we;
	logic [AW-1:0]               ram_waddr;
	logic [WW-1:0]               ram_wdata;
	logic [AW-1:0]               ram_raddr;
	logic [WW-1:0]               ram_rdata;
	logic [TID_BITS-1:0]         rd_tid;
	logic [wqt_pkg::ADDR_W-1:0]  rd_addr;
	logic                        is_wake;
	logic                        out_free;

	assign rd_tid   = ram_rdata[TID_BITS-1:0];
	assign rd_addr  = ram_rdata[WW-1:TID_BITS];
	assign is_wake  = (op_q == wqt_pkg::OP_WAKE);
	assign out_free = !out_valid_q || !out_stall;

	// Entry store: push writes at the top, a move copies the top into slot i
	assign ram_we    = cmd.push_wr || cmd.mov_wr;
	assign ram_waddr = cmd.push_wr ? AW'(cnt_q) : AW'(i_q);
	assign ram_wdata = cmd.push_wr ? {addr_q, tid_q} : ram_rdata;
	assign ram_raddr = cmd.rd_top ? AW'(cnt_q - CW'(1)) : AW'(i_q);

	wqt_ram #(
		.WIDTH (WW),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (cmd.rd_cur || cmd.rd_top),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Status to the controller
	always_comb begin
		sts.full       = (cnt_q == CW'(DEPTH));
		sts.scan_done  = (i_q >= cnt_q) || (is_wake && (left_q == '0));
		sts.match      = is_wake ? (rd_addr == addr_q) : (rd_tid == tid_q);
		sts.last_slot  = ((i_q + CW'(1)) == cnt_q);
		sts.out_free   = out_free;
		sts.pend_valid = pend_valid_q;
	end

	// Latch the item, and the thread id of each wake match
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q   <= wqt_pkg::op_t'(operation);
			addr_q <= wait_address;
			tid_q  <= TID_BITS'(thread_id);
		end
		if (cmd.take_match && is_wake) begin
			pend_tid_q <= rd_tid;
		end
	end

	// Scan index, budget (the entry count when wake_all is set), removal tally and pending woken thread
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q       <= '0;
			i_q          <= '0;
			removed_q    <= '0;
			pend_valid_q <= 1'b0;
		end else if (cmd.load) begin
			left_q       <= wake_all ? LW'(cnt_q) : LW'(wake_count);
			i_q          <= '0;
			removed_q    <= '0;
			pend_valid_q <= 1'b0;
		end else begin
			if (cmd.inc_i) begin
				i_q <= i_q + CW'(1);
			end
			if (cmd.take_match) begin
				if (is_wake) begin
					pend_valid_q <= 1'b1;
					left_q       <= left_q - LW'(1);
				end else begin
					removed_q <= removed_q + CW'(1);
				end
			end
		end
	end

	// Entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.push_wr) begin
			cnt_q <= cnt_q + CW'(1);
		end else if (cmd.dec_cnt) begin
			cnt_q <= cnt_q - CW'(1);
		end
	end

	// Result register valid: set on emit or on a further wake match, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit_push || cmd.emit_fin || (cmd.take_match && pend_valid_q)) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (cmd.emit_push) begin
			status_q      <= sts.full ? wqt_pkg::ST_FULL : wqt_pkg::ST_PUSHED;
			woken_q       <= '0;
			removed_out_q <= '0;
			last_q        <= 1'b1;
		end else if (cmd.take_match && pend_valid_q) begin
			// A further match shows the pending woken thread is not the last
			status_q      <= wqt_pkg::ST_WOKEN;
			woken_q       <= wqt_pkg::TID_W'(pend_tid_q);
			removed_out_q <= '0;
			last_q        <= 1'b0;
		end else if (cmd.emit_fin) begin
			if (!is_wake) begin
				status_q      <= wqt_pkg::ST_DROPPED;
				woken_q       <= '0;
				removed_out_q <= wqt_pkg::CNT_W'(removed_q);
			end else if (pend_valid_q) begin
				status_q      <= wqt_pkg::ST_WOKEN;
				woken_q       <= wqt_pkg::TID_W'(pend_tid_q);
				removed_out_q <= '0;
			end else begin
				status_q      <= wqt_pkg::ST_NONE;
				woken_q       <= '0;
				removed_out_q <= '0;
			end
			last_q <= 1'b1;
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign woken_thread  = woken_q;
	assign removed_count = removed_out_q;
	assign last          = last_q;

endmodule

/* rtl/wait_queue_table.sv */
// Wait queue table: up to DEPTH waiters (wait address, thread id) in one RAM.
// A push appends a waiter or reports the table full; a drop removes every
// waiter of a thread id and reports how many went; a wake scans in order and
// removes up to wake_count waiters on an address (all with wake_all), giving
// one woken item per thread with the final one marked by last, or a single
// none-woken item. A removed entry is refilled from the top of the table and
// that entry is checked in turn. The entry RAM has one read port with a
// registered read, so a drop or wake reads each visited entry before it
// compares it; operation code 3 is taken with no result. A result held by
// out_stall delays the next result of the same item. An item is taken
// while the previous result still waits on out_stall.
// Depends on wqt_pkg, wqt_ctrl, wqt_dpath, wqt_ram.
module wait_queue_table #(
	parameter int DEPTH    = wqt_pkg::DEPTH_DEF,
	parameter int TID_BITS = wqt_pkg::TID_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [wqt_pkg::OP_W-1:0]      operation,
	input  logic [wqt_pkg::ADDR_W-1:0]    wait_address,
	input  logic [wqt_pkg::TID_W-1:0]     thread_id,
	input  logic [wqt_pkg::CNT_W-1:0]     wake_count,
	input  logic                          wake_all,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [wqt_pkg::STATUS_W-1:0]  status,
	output logic [wqt_pkg::TID_W-1:0]     woken_thread,
	output logic [wqt_pkg::CNT_W-1:0]     removed_count,
	output logic                          last
);

	wqt_pkg::cmd_t cmd;
	wqt_pkg::sts_t sts;

	wqt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_op    (operation),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	wqt_dpath #(
		.DEPTH    (DEPTH),
		.TID_BITS (TID_BITS)
	) u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.operation     (operation),
		.wait_address  (wait_address),
		.thread_id     (thread_id),
		.wake_count    (wake_count),
		.wake_all      (wake_all),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.status        (status),
		.woken_thread  (woken_thread),
		.removed_count (removed_count),
		.last          (last)
	);

`ifndef SYNTHESIS
	// Only a woken item may be followed by more items of the same request
	a_last_unless_woken: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != wqt_pkg::ST_WOKEN) |-> last)
		else $error("non-woken item without last");

	a_removed_only_on_drop: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != wqt_pkg::ST_DROPPED) |-> (removed_count == '0))
		else $error("removed_count set outside a drop");

	a_thread_only_on_wake: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != wqt_pkg::ST_WOKEN) |-> (woken_thread == '0))
		else $error("woken_thread set outside a wake");

	// A real operation always makes the sequencer busy once it is taken
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (operation != wqt_pkg::OP_RSVD) |=> in_stall)
		else $error("item taken without the sequencer going busy");
`endif

endmodule
